[hw/rtl/two_source_delay_alignment_unit_defines.svh]
// ----------------------------------------------------------------------------
// Two-source delay alignment: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held
// off while the synchronous reset is high.
// ----------------------------------------------------------------------------
`ifndef TWO_SOURCE_DELAY_ALIGNMENT_UNIT_DEFINES_SVH
`define TWO_SOURCE_DELAY_ALIGNMENT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TDAU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdau same-cycle check failed");

// Next-cycle implication.
`define TDAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdau next-cycle check failed");

`endif

[hw/rtl/tdau_pkg.sv]
// ----------------------------------------------------------------------------
// tdau_pkg
// Types, codes and helpers shared by the delay alignment modules.
// ----------------------------------------------------------------------------
package tdau_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SYNC_ENABLED    = 3'd0;
  localparam logic [2:0] CFG_SYNC_MODE       = 3'd1;
  localparam logic [2:0] CFG_BASE_LATENCY    = 3'd2;
  localparam logic [2:0] CFG_MAX_OFFSET      = 3'd3;
  localparam logic [2:0] CFG_MANUAL_OFFSET   = 3'd4;
  localparam logic [2:0] CFG_LOCK_CONFIDENCE = 3'd5;

  // Request codes
  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_SLEW  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OFF       = 3'd0;
  localparam logic [2:0] ST_MANUAL    = 3'd1;
  localparam logic [2:0] ST_SEARCHING = 3'd2;
  localparam logic [2:0] ST_HOLDING   = 3'd3;
  localparam logic [2:0] ST_LOCKED    = 3'd4;
  localparam logic [2:0] ST_LOW_CONF  = 3'd5;

  // Last surface code that gets a display delay (audio..meter)
  localparam logic [2:0] SURF_LAST_DISPLAY = 3'd3;

  // Slew rule, Q16 unity, delay saturation
  localparam logic signed [13:0] DEADBAND_MS  = 14'sd15;
  localparam logic signed [13:0] STEP_MS      = 14'sd20;
  localparam logic signed [13:0] SLEW_MIN     = -14'sd4096;
  localparam logic signed [13:0] SLEW_MAX     = 14'sd4095;
  localparam logic [16:0]        CONF_ONE     = 17'd65536;
  localparam logic [11:0]        DELAY_SAT    = 12'hFFF;

  typedef struct packed {
    logic        sync_enabled;
    logic        sync_mode;
    logic [10:0] base_latency_ms;
    logic [9:0]  max_offset_ms;
    logic [10:0] manual_offset_ms;   // two's complement
    logic [16:0] lock_confidence;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        held;
    logic [10:0] offset;             // two's complement
    logic [16:0] confidence;
  } est_t;

  typedef struct packed {
    logic [11:0] first_delay;
    logic [11:0] second_delay;
    logic [10:0] eff_offset;         // two's complement
    logic [2:0]  status;
  } breakdown_t;

  function automatic logic [16:0] clamp_conf(input logic [16:0] c);
    clamp_conf = (c > CONF_ONE) ? CONF_ONE : c;
  endfunction

endpackage

[hw/rtl/tdau_if.sv]
// ----------------------------------------------------------------------------
// tdau interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface tdau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic               source_sel;
  logic [2:0]         surface_sel;
  logic [47:0]        arrival_ms;
  logic               new_est_valid;
  logic               new_est_held;
  logic signed [12:0] new_est_offset_ms;
  logic [16:0]        new_est_confidence;
  logic signed [12:0] current_offset_ms;
  logic signed [12:0] candidate_offset_ms;
  logic               slew_reset;

  modport source (
    output valid, req_type, source_sel, surface_sel, arrival_ms, new_est_valid,
           new_est_held, new_est_offset_ms, new_est_confidence, current_offset_ms,
           candidate_offset_ms, slew_reset,
    input  ready
  );
  modport sink (
    input  valid, req_type, source_sel, surface_sel, arrival_ms, new_est_valid,
           new_est_held, new_est_offset_ms, new_est_confidence, current_offset_ms,
           candidate_offset_ms, slew_reset,
    output ready
  );
endinterface

interface tdau_rsp_if;
  logic               valid;
  logic               ready;
  logic [47:0]        due_ms;
  logic [11:0]        surface_delay_ms;
  logic [11:0]        first_delay_ms;
  logic [11:0]        second_delay_ms;
  logic signed [10:0] effective_offset_ms;
  logic [2:0]         sync_status;
  logic signed [12:0] slewed_offset_ms;

  modport source (
    output valid, due_ms, surface_delay_ms, first_delay_ms, second_delay_ms,
           effective_offset_ms, sync_status, slewed_offset_ms,
    input  ready
  );
  modport sink (
    input  valid, due_ms, surface_delay_ms, first_delay_ms, second_delay_ms,
           effective_offset_ms, sync_status, slewed_offset_ms,
    output ready
  );
endinterface

interface tdau_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tdau_slew.sv]
// ----------------------------------------------------------------------------
// tdau_slew
// Moves an offset toward a candidate: 15 ms deadband, 20 ms step limit.
// ----------------------------------------------------------------------------
module tdau_slew (
  input  logic signed [12:0] cur,
  input  logic signed [12:0] cand,
  input  logic               jump,
  output logic signed [12:0] result
);

  logic signed [13:0] diff;
  logic signed [13:0] step;
  logic signed [13:0] moved;

  always_comb begin
    diff = 14'(cand) - 14'(cur);
    if (diff > tdau_pkg::STEP_MS) begin
      step = tdau_pkg::STEP_MS;
    end else if (diff < -tdau_pkg::STEP_MS) begin
      step = -tdau_pkg::STEP_MS;
    end else begin
      step = diff;
    end
    moved = 14'(cur) + step;
    if (jump) begin
      result = cand;
    end else if (diff >= -tdau_pkg::DEADBAND_MS && diff <= tdau_pkg::DEADBAND_MS) begin
      result = cur;
    end else if (moved > tdau_pkg::SLEW_MAX) begin
      result = tdau_pkg::SLEW_MAX[12:0];
    end else if (moved < tdau_pkg::SLEW_MIN) begin
      result = tdau_pkg::SLEW_MIN[12:0];
    end else begin
      result = moved[12:0];
    end
  end

endmodule

[hw/rtl/tdau_calc.sv]
// ----------------------------------------------------------------------------
// tdau_calc
// Effective offset, per-source delays and status from config and estimate.
// ----------------------------------------------------------------------------
module tdau_calc (
  input  tdau_pkg::cfg_t       cfg,
  input  tdau_pkg::est_t       est,
  input  logic [9:0]           max_off,
  input  logic [10:0]          base_lat,
  output tdau_pkg::breakdown_t bd
);

  logic               locked;
  logic               use_auto;
  logic signed [10:0] raw;
  logic signed [10:0] lim;
  logic signed [10:0] eff;
  logic [10:0]        mag;
  logic [12:0]        first_sum;
  logic [12:0]        second_sum;

  always_comb begin
    locked   = est.confidence >= tdau_pkg::clamp_conf(cfg.lock_confidence);
    use_auto = cfg.sync_mode && est.valid && (est.held || locked);
    raw      = use_auto ? $signed(est.offset) : $signed(cfg.manual_offset_ms);
    lim      = $signed({1'b0, max_off});
    if (raw > lim) begin
      eff = lim;
    end else if (raw < -lim) begin
      eff = -lim;
    end else begin
      eff = raw;
    end
    mag = eff[10] ? 11'(-eff) : eff;   // |eff| <= 1023

    first_sum  = {2'b00, base_lat} + (eff[10] ? 13'd0 : {2'b00, mag});
    second_sum = {2'b00, base_lat} + (eff[10] ? {2'b00, mag} : 13'd0);

    if (!cfg.sync_enabled) begin
      bd = '0;
      bd.status = tdau_pkg::ST_OFF;
    end else begin
      bd.first_delay  = first_sum[12]  ? tdau_pkg::DELAY_SAT : first_sum[11:0];
      bd.second_delay = second_sum[12] ? tdau_pkg::DELAY_SAT : second_sum[11:0];
      bd.eff_offset   = eff;
      if (!cfg.sync_mode) begin
        bd.status = tdau_pkg::ST_MANUAL;
      end else if (!est.valid) begin
        bd.status = tdau_pkg::ST_SEARCHING;
      end else if (est.held) begin
        bd.status = tdau_pkg::ST_HOLDING;
      end else if (locked) begin
        bd.status = tdau_pkg::ST_LOCKED;
      end else begin
        bd.status = tdau_pkg::ST_LOW_CONF;
      end
    end
  end

endmodule

[hw/rtl/two_source_delay_alignment_unit.sv]
// ----------------------------------------------------------------------------
// two_source_delay_alignment_unit
// Path: a request transaction passes through the input register, then the
//   result register, to result valid; nothing inside the block stalls it.
// Throughput: 1 transaction per cycle while the result side is ready, set by the
//   single pass from the input register through estimate update and delay math into the result register.
// Reset: clears the estimate, valid flags and registers (max offset 1000).
// ----------------------------------------------------------------------------
`include "two_source_delay_alignment_unit_defines.svh"

module two_source_delay_alignment_unit #(
  parameter int MAX_OFFSET_LIMIT_MS = 1000,
  parameter int MIN_BASE_LATENCY_MS = 0,
  parameter int MAX_BASE_LATENCY_MS = 2000
) (
  input  logic              clk,
  input  logic              rst,
  tdau_cfg_if.sink          cfg,
  tdau_req_if.sink          req,
  tdau_rsp_if.source        rsp
);

  // Parameter limits as vectors; register fields are three bits narrower than these.
  localparam logic [12:0] OFF_LIMIT = 13'(MAX_OFFSET_LIMIT_MS);
  localparam logic [13:0] BASE_MIN  = 14'(MIN_BASE_LATENCY_MS);
  localparam logic [13:0] BASE_MAX  = 14'(MAX_BASE_LATENCY_MS);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are for the user to make only while the block is
  // idle; the block itself does not enforce this, and the port is always ready.
  // --------------------------------------------------------------------------
  tdau_pkg::cfg_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{max_offset_ms: 10'd1000, default: '0};
    end else if (cfg.valid) begin
      case (cfg.index)
        tdau_pkg::CFG_SYNC_ENABLED:    regs.sync_enabled     <= cfg.data[0];
        tdau_pkg::CFG_SYNC_MODE:       regs.sync_mode        <= cfg.data[0];
        tdau_pkg::CFG_BASE_LATENCY:    regs.base_latency_ms  <= cfg.data[10:0];
        tdau_pkg::CFG_MAX_OFFSET:      regs.max_offset_ms    <= cfg.data[9:0];
        tdau_pkg::CFG_MANUAL_OFFSET:   regs.manual_offset_ms <= cfg.data[10:0];
        tdau_pkg::CFG_LOCK_CONFIDENCE: regs.lock_confidence  <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  // Clamp register values to the parameter limits.
  logic [9:0]  max_off;
  logic [13:0] base_ext;
  logic [13:0] base_c;
  logic [10:0] base_lat;

  always_comb begin
    max_off  = ({3'b000, regs.max_offset_ms} > OFF_LIMIT) ? OFF_LIMIT[9:0]
                                                          : regs.max_offset_ms;
    base_ext = {3'b000, regs.base_latency_ms};
    if (base_ext < BASE_MIN) begin
      base_c = BASE_MIN;
    end else if (base_ext > BASE_MAX) begin
      base_c = BASE_MAX;
    end else begin
      base_c = base_ext;
    end
    base_lat = base_c[10:0];   // max limit 2000, so never above 2047
  end

  // --------------------------------------------------------------------------
  // Input register. Moves on whenever the result register is free or being
  // drained this cycle; a waiting result that is not drained holds the next request.
  // --------------------------------------------------------------------------
  logic               s1_valid;
  logic [1:0]         s1_req_type;
  logic               s1_source_sel;
  logic [2:0]         s1_surface_sel;
  logic [47:0]        s1_arrival_ms;
  logic               s1_new_valid;
  logic               s1_new_held;
  logic signed [12:0] s1_new_offset;
  logic [16:0]        s1_new_conf;
  logic signed [12:0] s1_cur_offset;
  logic signed [12:0] s1_cand_offset;
  logic               s1_slew_reset;

  logic out_valid;
  logic adv;

  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req_type    <= req.req_type;
      s1_source_sel  <= req.source_sel;
      s1_surface_sel <= req.surface_sel;
      s1_arrival_ms  <= req.arrival_ms;
      s1_new_valid   <= req.new_est_valid;
      s1_new_held    <= req.new_est_held;
      s1_new_offset  <= req.new_est_offset_ms;
      s1_new_conf    <= req.new_est_confidence;
      s1_cur_offset  <= req.current_offset_ms;
      s1_cand_offset <= req.candidate_offset_ms;
      s1_slew_reset  <= req.slew_reset;
    end
  end

  // --------------------------------------------------------------------------
  // Estimate update. Results report the state after this transaction's
  // update, so the delay math reads est_next rather than est.
  // --------------------------------------------------------------------------
  tdau_pkg::est_t     est;
  tdau_pkg::est_t     est_next;
  logic signed [12:0] off_lim;
  logic signed [12:0] load_off;

  always_comb begin
    off_lim = $signed({3'b000, max_off});
    if (s1_new_offset > off_lim) begin
      load_off = off_lim;
    end else if (s1_new_offset < -off_lim) begin
      load_off = -off_lim;
    end else begin
      load_off = s1_new_offset;
    end

    case (s1_req_type)
      tdau_pkg::REQ_LOAD: begin
        est_next.valid      = s1_new_valid;
        est_next.held       = s1_new_held;
        est_next.offset     = load_off[10:0];
        est_next.confidence = tdau_pkg::clamp_conf(s1_new_conf);
      end
      tdau_pkg::REQ_CLEAR: begin
        est_next = '0;
      end
      default: begin
        est_next = est;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
    end else if (adv) begin
      est <= est_next;
    end
  end

  // --------------------------------------------------------------------------
  // Delay breakdown and slew.
  // --------------------------------------------------------------------------
  tdau_pkg::breakdown_t bd;
  logic signed [12:0]   slew_out;

  tdau_calc u_calc (
    .cfg      (regs),
    .est      (est_next),
    .max_off  (max_off),
    .base_lat (base_lat),
    .bd       (bd)
  );

  tdau_slew u_slew (
    .cur    (s1_cur_offset),
    .cand   (s1_cand_offset),
    .jump   (s1_slew_reset),
    .result (slew_out)
  );

  // Analyzer, decoder, recording (and the spare code) get no delay.
  logic [11:0] sdelay;

  always_comb begin
    if (s1_surface_sel <= tdau_pkg::SURF_LAST_DISPLAY) begin
      sdelay = s1_source_sel ? bd.second_delay : bd.first_delay;
    end else begin
      sdelay = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.due_ms              <= s1_arrival_ms + {36'd0, sdelay};   // wraps mod 2^48
      rsp.surface_delay_ms    <= sdelay;
      rsp.first_delay_ms      <= bd.first_delay;
      rsp.second_delay_ms     <= bd.second_delay;
      rsp.effective_offset_ms <= bd.eff_offset;
      rsp.sync_status         <= bd.status;
      rsp.slewed_offset_ms    <= (s1_req_type == tdau_pkg::REQ_SLEW) ? slew_out : 13'sd0;
    end
  end

  assign rsp.valid = out_valid;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  logic adv_clear;
  logic adv_query;
  logic est_empty;

  assign adv_clear = adv && (s1_req_type == tdau_pkg::REQ_CLEAR);
  assign adv_query = adv && (s1_req_type == tdau_pkg::REQ_QUERY);
  assign est_empty = !est.valid && !est.held && (est.confidence == '0);

  `TDAU_ASSERT_NEXT(a_clear_empties_est, clk, rst, adv_clear, est_empty)
  `TDAU_ASSERT_NOW(a_conf_in_range, clk, rst, 1'b1, est.confidence <= tdau_pkg::CONF_ONE)
  `TDAU_ASSERT_NEXT(a_adv_fills_result, clk, rst, adv, out_valid)
  `TDAU_ASSERT_NEXT(a_query_keeps_est, clk, rst, adv_query, $stable(est))

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: two-source delay alignment testbench
// Sends request transactions (query, load, clear, slew) under several register
// settings and with random gaps on both sides. A behavioral predictor tracks
// the delay estimate and the registers, and each result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdau_pkg::*;

  // Block parameters, kept here so that the predictor uses the same limits
  localparam int OFFSET_LIMIT = 1000;
  localparam int BASE_MIN     = 0;
  localparam int BASE_MAX     = 2000;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 6;       // extra wait after the last result returns
  localparam int LIMIT_CYCLES   = 400000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 135;
  localparam int SHOW_LIMIT     = 10;
  localparam int CONF_MAX       = 65536;   // Q16 unity
  localparam logic [2:0] CFG_UNUSED = 3'd7;  // no register behind this index

  typedef struct packed {
    logic [1:0]         kind;
    logic               src;
    logic [2:0]         surf;
    logic [47:0]        arrival;
    logic               ld_valid;
    logic               ld_held;
    logic signed [12:0] ld_off;
    logic [16:0]        ld_conf;
    logic signed [12:0] cur_off;
    logic signed [12:0] cand_off;
    logic               jump;
  } request_t;

  typedef struct packed {
    logic [47:0]        due;
    logic [11:0]        surf_delay;
    logic [11:0]        first_delay;
    logic [11:0]        second_delay;
    logic signed [10:0] eff_offset;
    logic [2:0]         status;
    logic signed [12:0] slewed;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdau_cfg_if cfg_ch ();
  tdau_req_if req_ch ();
  tdau_rsp_if rsp_ch ();

  two_source_delay_alignment_unit #(
    .MAX_OFFSET_LIMIT_MS(OFFSET_LIMIT),
    .MIN_BASE_LATENCY_MS(BASE_MIN),
    .MAX_BASE_LATENCY_MS(BASE_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies held by the predictor
  bit cfg_enabled;
  bit cfg_auto;
  int cfg_base;
  int cfg_max_off;
  int cfg_manual;
  int cfg_lock;

  // Delay estimate as the predictor sees it
  bit est_valid;
  bit est_held;
  int est_off;
  int est_conf;

  request_t pending_reqs[$];       // waiting to be driven
  result_t  expected_results[$];   // predicted, not yet returned

  int n_queued;
  int n_accepted;
  int n_results;
  int n_settings;
  int kind_count[4];
  int fail_count;
  int shown;
  int cycle_count;
  int sender_idle_pct;
  int recv_idle_pct;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Deadband, then a bounded step toward the candidate.
  function automatic int slew_step(int cur, int cand, bit jump);
    int d;
    if (jump) return cand;
    d = cand - cur;
    if (d >= -int'(DEADBAND_MS) && d <= int'(DEADBAND_MS)) return cur;
    return clip(cur + clip(d, -int'(STEP_MS), int'(STEP_MS)),
                int'(SLEW_MIN), int'(SLEW_MAX));
  endfunction

  // Applies the estimate update of one request, then works out the
  // breakdown and due time from the updated state.
  function automatic result_t predict_alignment(request_t r);
    int      m;
    int      lk;
    int      base;
    int      eff;
    int      first_d;
    int      second_d;
    int      sdelay;
    int      slewed;
    logic [2:0] status;
    result_t res;
    m      = clip(cfg_max_off, 0, OFFSET_LIMIT);
    lk     = clip(cfg_lock, 0, CONF_MAX);
    eff    = 0;
    first_d  = 0;
    second_d = 0;
    sdelay = 0;
    slewed = 0;
    status = ST_OFF;
    case (r.kind)
      REQ_LOAD: begin
        est_valid = r.ld_valid;
        est_held  = r.ld_held;
        est_off   = clip(int'(r.ld_off), -m, m);
        est_conf  = clip(int'(r.ld_conf), 0, CONF_MAX);
      end
      REQ_CLEAR: begin
        est_valid = 1'b0;
        est_held  = 1'b0;
        est_off   = 0;
        est_conf  = 0;
      end
      REQ_SLEW: slewed = slew_step(int'(r.cur_off), int'(r.cand_off), r.jump);
      default: ;
    endcase
    if (cfg_enabled) begin
      base = clip(cfg_base, BASE_MIN, BASE_MAX);
      if (cfg_auto && est_valid && (est_held || est_conf >= lk))
        eff = clip(est_off, -m, m);
      else
        eff = clip(cfg_manual, -m, m);
      first_d  = clip(base + ((eff > 0) ? eff : 0), 0, 4095);
      second_d = clip(base + ((eff < 0) ? -eff : 0), 0, 4095);
      if (!cfg_auto)           status = ST_MANUAL;
      else if (!est_valid)     status = ST_SEARCHING;
      else if (est_held)       status = ST_HOLDING;
      else if (est_conf >= lk) status = ST_LOCKED;
      else                     status = ST_LOW_CONF;
    end
    if (r.surf <= SURF_LAST_DISPLAY) sdelay = r.src ? second_d : first_d;
    res.due          = r.arrival + 48'(sdelay);
    res.surf_delay   = 12'(sdelay);
    res.first_delay  = 12'(first_d);
    res.second_delay = 12'(second_d);
    res.eff_offset   = 11'(eff);
    res.status       = status;
    res.slewed       = 13'(slewed);
    return res;
  endfunction

  function automatic string show_result(result_t x);
    return $sformatf("due=%h sdly=%0d d1=%0d d2=%0d eff=%0d st=%0d slew=%0d",
                     x.due, x.surf_delay, x.first_delay, x.second_delay,
                     x.eff_offset, x.status, x.slewed);
  endfunction

  // Every field random, every bit reachable
  function automatic request_t rand_request();
    request_t r;
    r.kind     = 2'($urandom);
    r.src      = 1'($urandom);
    r.surf     = 3'($urandom);
    r.arrival  = 48'({$urandom(), $urandom()});
    r.ld_valid = 1'($urandom);
    r.ld_held  = 1'($urandom);
    r.ld_off   = 13'($urandom);
    r.ld_conf  = 17'($urandom);
    r.cur_off  = 13'($urandom);
    r.cand_off = 13'($urandom);
    r.jump     = 1'($urandom);
    return r;
  endfunction

  // Random request shaped toward the interesting corners of the current
  // setting: estimates near the lock threshold and offset limit, slews near
  // the deadband and step edges, arrivals near the 48-bit wrap.
  function automatic request_t shaped_request();
    request_t r;
    int       pick;
    int       m;
    int       lk;
    int       delta;
    r    = rand_request();
    pick = $urandom_range(99);
    m    = clip(cfg_max_off, 0, OFFSET_LIMIT);
    lk   = clip(cfg_lock, 0, CONF_MAX);
    if ($urandom_range(9) == 0) r.arrival = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3000));
    if (pick < 40) begin
      r.kind = REQ_QUERY;
    end else if (pick < 65) begin
      r.kind = REQ_LOAD;
      r.ld_valid = ($urandom_range(4) != 0);
      r.ld_held  = ($urandom_range(3) == 0);
      if ($urandom_range(1)) begin
        r.ld_off = 13'(m + $urandom_range(2) - 1);
        if ($urandom_range(1)) r.ld_off = -r.ld_off;
      end else if ($urandom_range(1)) begin
        r.ld_off = 13'(int'($urandom_range(2 * m + 1)) - m);
      end
      case ($urandom_range(4))
        0, 1:    r.ld_conf = 17'(clip(lk + int'($urandom_range(2)) - 1, 0, 131071));
        2:       r.ld_conf = 17'(CONF_MAX);
        3:       r.ld_conf = 17'($urandom_range(CONF_MAX));
        default: ;
      endcase
    end else if (pick < 73) begin
      r.kind = REQ_CLEAR;
    end else begin
      r.kind = REQ_SLEW;
      r.jump = ($urandom_range(9) == 0);
      if ($urandom_range(1)) r.cur_off = 13'(int'($urandom_range(2000)) - 1000);
      case ($urandom_range(3))
        0:       delta = int'($urandom_range(2)) + 14;
        1:       delta = int'($urandom_range(2)) + 19;
        2:       delta = int'($urandom_range(40));
        default: delta = int'($urandom_range(8191));
      endcase
      if ($urandom_range(1)) delta = -delta;
      r.cand_off = 13'(clip(int'(r.cur_off) + delta, -4096, 4095));
    end
    return r;
  endfunction

  task automatic queue_req(request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    n_queued++;
  endtask

  task automatic queue_query(logic src, logic [2:0] surf, logic [47:0] arrival);
    request_t r;
    r         = rand_request();
    r.kind    = REQ_QUERY;
    r.src     = src;
    r.surf    = surf;
    r.arrival = arrival;
    queue_req(r);
  endtask

  task automatic queue_load(logic v, logic h, logic signed [12:0] off, logic [16:0] conf);
    request_t r;
    r          = rand_request();
    r.kind     = REQ_LOAD;
    r.ld_valid = v;
    r.ld_held  = h;
    r.ld_off   = off;
    r.ld_conf  = conf;
    queue_req(r);
  endtask

  task automatic queue_slew(logic signed [12:0] cur, logic signed [12:0] cand, logic jump);
    request_t r;
    r          = rand_request();
    r.kind     = REQ_SLEW;
    r.cur_off  = cur;
    r.cand_off = cand;
    r.jump     = jump;
    queue_req(r);
  endtask

  // One register write transaction; the predictor copy changes at the
  // edge where the write is taken.
  task automatic cfg_write(logic [2:0] idx, logic [16:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SYNC_ENABLED:    cfg_enabled = value[0];
      CFG_SYNC_MODE:       cfg_auto    = value[0];
      CFG_BASE_LATENCY:    cfg_base    = int'(value[10:0]);
      CFG_MAX_OFFSET:      cfg_max_off = int'(value[9:0]);
      CFG_MANUAL_OFFSET:   cfg_manual  = $signed(value[10:0]);
      CFG_LOCK_CONFIDENCE: cfg_lock    = int'(value[16:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int en, int auto_mode, int base, int max_off,
                                int manual, int lock);
    cfg_write(CFG_SYNC_ENABLED, 17'(en & 1));
    cfg_write(CFG_SYNC_MODE, 17'(auto_mode & 1));
    cfg_write(CFG_BASE_LATENCY, 17'(base & 'h7FF));
    cfg_write(CFG_MAX_OFFSET, 17'(max_off & 'h3FF));
    cfg_write(CFG_MANUAL_OFFSET, 17'(manual & 'h7FF));
    cfg_write(CFG_LOCK_CONFIDENCE, 17'(lock & 'h1FFFF));
    n_settings++;
  endtask

  // Pending list empty, every driven transaction taken and answered.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || n_accepted != n_queued ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request driver: holds a transaction until it is taken, then either
  // moves to the next pending one or idles, at the current gap rate.
  request_t cur_req;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.insert(expected_results.size(), predict_alignment(cur_req));
        kind_count[cur_req.kind]++;
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          req_ch.req_type            <= cur_req.kind;
          req_ch.source_sel          <= cur_req.src;
          req_ch.surface_sel         <= cur_req.surf;
          req_ch.arrival_ms          <= cur_req.arrival;
          req_ch.new_est_valid       <= cur_req.ld_valid;
          req_ch.new_est_held        <= cur_req.ld_held;
          req_ch.new_est_offset_ms   <= cur_req.ld_off;
          req_ch.new_est_confidence  <= cur_req.ld_conf;
          req_ch.current_offset_ms   <= cur_req.cur_off;
          req_ch.candidate_offset_ms <= cur_req.cand_off;
          req_ch.slew_reset          <= cur_req.jump;
          req_ch.valid               <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, in-order compare.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.due          = rsp_ch.due_ms;
        got.surf_delay   = rsp_ch.surface_delay_ms;
        got.first_delay  = rsp_ch.first_delay_ms;
        got.second_delay = rsp_ch.second_delay_ms;
        got.eff_offset   = rsp_ch.effective_offset_ms;
        got.status       = rsp_ch.sync_status;
        got.slewed       = rsp_ch.slewed_offset_ms;
        n_results++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("[%0t] unexpected result: %s", $realtime, show_result(got));
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("[%0t] mismatch on result %0d", $realtime, n_results);
              $display("  expected %s", show_result(want));
              $display("  actual   %s", show_result(got));
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAIL two_source_delay_alignment_unit");
      $finish;
    end
  end

  // Stimulus sequencer
  initial begin
    int half;
    // Known values on every input before the first edge
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SYNC_ENABLED;
    cfg_ch.data  = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_QUERY;
    req_ch.source_sel = 1'b0;
    req_ch.surface_sel = '0;
    req_ch.arrival_ms = '0;
    req_ch.new_est_valid = 1'b0;
    req_ch.new_est_held = 1'b0;
    req_ch.new_est_offset_ms = '0;
    req_ch.new_est_confidence = '0;
    req_ch.current_offset_ms = '0;
    req_ch.candidate_offset_ms = '0;
    req_ch.slew_reset = 1'b0;
    rsp_ch.ready = 1'b0;

    // Reset values of the register copies and the estimate
    cfg_enabled = 1'b0;
    cfg_auto    = 1'b0;
    cfg_base    = 0;
    cfg_max_off = 1000;
    cfg_manual  = 0;
    cfg_lock    = 0;
    est_valid   = 1'b0;
    est_held    = 1'b0;
    est_off     = 0;
    est_conf    = 0;

    // Sender gaps light, receiver stalls heavy for the first third
    sender_idle_pct = 12;
    recv_idle_pct   = 51;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part: auto mode, lock at one half
    apply_settings(1, 1, 100, 1000, -300, 32768);
    queue_query(1'b0, 3'd0, 48'd0);                        // nothing loaded: searching
    queue_load(1'b1, 1'b0, 13'sd4095, 17'h1FFFF);          // offset and confidence clamp
    queue_query(1'b1, 3'd3, 48'hFFFF_FFFF_FFFF);           // due time wraps
    queue_load(1'b1, 1'b1, -13'sd4096, 17'd0);             // held despite zero confidence
    queue_query(1'b1, 3'd2, 48'h8000_0000_0000);
    queue_load(1'b1, 1'b0, -13'sd250, 17'd32767);          // just below lock: manual used
    queue_load(1'b1, 1'b0, -13'sd250, 17'd32768);          // exactly at lock
    queue_load(1'b0, 1'b1, 13'sd500, 17'd65536);           // invalid estimate
    queue_load(1'b1, 1'b0, 13'sd700, 17'd65536);
    queue_req('{kind: REQ_CLEAR, default: '0});
    for (int s = 0; s < 8; s++)                            // every surface, code 7 too
      queue_query(1'(s), 3'(s), 48'hFFFF_FFFF_FF00 + 48'(s));
    queue_slew(13'sd0, -13'sd4096, 1'b1);                  // jump
    queue_slew(13'sd100, 13'sd115, 1'b0);                 // deadband edge
    queue_slew(13'sd100, 13'sd116, 1'b0);                 // just past deadband
    queue_slew(13'sd100, 13'sd85, 1'b0);
    queue_slew(13'sd100, 13'sd84, 1'b0);
    queue_slew(-13'sd4096, 13'sd4095, 1'b0);               // full-scale step up
    queue_slew(13'sd4095, -13'sd4096, 1'b0);               // full-scale step down
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      // Idle profile: swap after a third, none in the last third
      if (p == PHASES / 3) begin
        sender_idle_pct = 51;
        recv_idle_pct   = 12;
      end else if (p == 2 * PHASES / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      case (p)
        0: apply_settings(1, 1, 100, 1000, -300, 32768);
        1: apply_settings(1, 0, 2047, 1023, -1024, 0);      // manual, above base and max limits
        2: begin
          apply_settings(0, 1, 500, 200, 50, 100);          // alignment off
          cfg_write(CFG_UNUSED, 17'h1ABCD);                 // write to an empty index is ignored
        end
        3: apply_settings(1, 1, 0, 0, 1023, 131071);        // zero max offset, lock above unity
        4: apply_settings(1, 1, 2000, 1000, 1000, 65536);
        5: apply_settings(1, 1, 37, 1, -1, 0);              // lock at zero: always locked
        default: apply_settings(($urandom_range(7) != 0), $urandom_range(1),
                                $urandom_range(2047), $urandom_range(1023),
                                $urandom_range(2047), $urandom_range(131071));
      endcase
      // Estimate starts each phase from a fresh load most of the time
      if ($urandom_range(3) != 0) queue_load(1'b1, 1'($urandom), 13'($urandom), 17'($urandom));
      half = PHASE_ITEMS / 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        queue_req(shaped_request());
        // Mid-phase hold-off: stop sending until every result is back
        if (p == PHASES / 2 && i == half) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    if (expected_results.size() != 0) fail_count++;
    $display("Covered %0d transactions: %0d queries, %0d loads, %0d clears, %0d slews",
             n_accepted, kind_count[REQ_QUERY], kind_count[REQ_LOAD],
             kind_count[REQ_CLEAR], kind_count[REQ_SLEW]);
    $display("%0d results checked over %0d register settings, %0d failures",
             n_results, n_settings, fail_count);
    if (fail_count == 0) begin
      $display("PASS two_source_delay_alignment_unit");
    end else begin
      $display("FAIL two_source_delay_alignment_unit");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tdau_pkg.sv
hw/rtl/tdau_if.sv
hw/rtl/tdau_slew.sv
hw/rtl/tdau_calc.sv
hw/rtl/two_source_delay_alignment_unit.sv
dv/tb_top.sv
